// ----- rtl/bpra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page run allocator package
// Shared constants: field widths, request modes, zone codes, status codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package bpra_pkg;

	// Bitmap word geometry and run limits.
	localparam int WORD_BITS = 64;
	localparam int WORD_LSB  = 6;
	localparam int MAX_RUN   = 63;

	// Field widths of the request and response.
	localparam int MODE_W  = 2;
	localparam int ZONE_W  = 2;
	localparam int COUNT_W = 6;
	localparam int INDEX_W = 12;
	localparam int STAT_W  = 2;

	// Configuration port.
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DMA_END    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd2;
	localparam logic [CFG_W-1:0]     TOTAL_RESET    = 13'd4096;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

	// Zone codes for allocate.
	localparam logic [ZONE_W-1:0] ZSEL_DMA      = 2'd0;
	localparam logic [ZONE_W-1:0] ZSEL_NORMAL   = 2'd1;
	localparam logic [ZONE_W-1:0] ZSEL_UNMAPPED = 2'd2;

	// Response status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_RUN    = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_ZONE  = 2'd3;

endpackage

// ----- rtl/bitmap_page_run_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit allocator of contiguous page runs over a used-page bitmap held in
// a synchronous memory of 64-bit words. Also frees and marks runs.
// ----------------------------------------------------------------------------
//  Channel   Signals                                          Direction
//  request   in_valid, in_stall, mode, zone_select,           in (stall out)
//            page_count, page_index
//  response  out_valid, out_stall, status, first_page         out (stall in)
//  config    cfg_we, cfg_index, cfg_data                      in
//
//  Free and mark-used do one read and one write per bitmap word touched, at
//  most two words. Allocate scans one bitmap word per cycle through the memory
//  read port, then marks the run found. Errors go straight to the response
//  state. One request is in work at a time.
//  Reset frees every page at once through per-word valid bits; no clearing
//  pass is needed. A stalled response is held while the next request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_unit #(
	parameter int PAGE_TOTAL = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration
	input  logic                            cfg_we,
	input  logic [bpra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpra_pkg::CFG_W-1:0]      cfg_data,
	// Request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bpra_pkg::MODE_W-1:0]     mode,
	input  logic [bpra_pkg::ZONE_W-1:0]     zone_select,
	input  logic [bpra_pkg::COUNT_W-1:0]    page_count,
	input  logic [bpra_pkg::INDEX_W-1:0]    page_index,
	// Response channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bpra_pkg::STAT_W-1:0]     status,
	output logic [bpra_pkg::INDEX_W-1:0]    first_page
);

	localparam int WB    = bpra_pkg::WORD_BITS;
	localparam int LSB   = bpra_pkg::WORD_LSB;
	localparam int NW    = (PAGE_TOTAL + WB - 1) / WB;
	localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int PW    = $clog2(PAGE_TOTAL + 1);
	localparam int WCW   = PW - LSB;
	localparam int SW    = (PW > bpra_pkg::INDEX_W) ? PW : bpra_pkg::INDEX_W;
	localparam int FULLW = PAGE_TOTAL / WB;
	localparam int REMB  = PAGE_TOTAL % WB;
	localparam int CW    = bpra_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RUN_RD,
		ST_RUN_LO,
		ST_RUN_HI,
		ST_RESP
	} state_t;

	state_t                        state_q;
	logic [bpra_pkg::CFG_W-1:0]    dma_end_q;
	logic [bpra_pkg::CFG_W-1:0]    normal_end_q;
	logic [bpra_pkg::CFG_W-1:0]    total_q;
	logic [CW-1:0]                 cnt_q;
	logic [SW-1:0]                 run_start_q;
	logic                          set_q;
	logic [PW-1:0]                 zs_q;
	logic [PW-1:0]                 ze_q;
	logic [WCW-1:0]                iss_w_q;
	logic [WCW-1:0]                last_w_q;
	logic                          iss_done_q;
	logic                          chk_v_s1;
	logic [WCW-1:0]                chk_w_s1;
	logic [WB-1:0]                 prev_free_q;
	logic [bpra_pkg::STAT_W-1:0]   res_status_q;
	logic [bpra_pkg::INDEX_W-1:0]  res_first_q;
	logic                          out_valid_q;
	logic [bpra_pkg::STAT_W-1:0]   status_q;
	logic [bpra_pkg::INDEX_W-1:0]  first_page_q;

	// Memory port signals.
	logic                          rd_en;
	logic [WAW-1:0]                rd_addr;
	logic [WB-1:0]                 rd_data;
	logic                          wr_en;
	logic [WAW-1:0]                wr_addr;
	logic [WB-1:0]                 wr_data;

	// Mask of pages in word w that exist in the bitmap.
	function automatic logic [WB-1:0] lim_mask(input int unsigned w);
		logic [WB-1:0] m;
		if (w < FULLW) begin
			m = '1;
		end else if (w == FULLW && REMB != 0) begin
			m = (WB'(1) << REMB) - WB'(1);
		end else begin
			m = '0;
		end
		return m;
	endfunction

	// Positions in the upper word at which a run of cnt free pages ends.
	// Windows are built by doubling: a holds blocks of 2^k, v the partial run.
	function automatic logic [WB-1:0] run_ends(input logic [2*WB-1:0] ext,
			input logic [CW-1:0] cnt);
		logic [2*WB-1:0] a;
		logic [2*WB-1:0] v;
		a = ext;
		v = '1;
		for (int k = 0; k < CW; k++) begin
			if (cnt[k]) begin
				v = a & (v << (1 << k));
			end
			a = a & (a << (1 << k));
		end
		return v[2*WB-1:WB];
	endfunction

	// Lowest set bit of a word.
	function automatic logic [LSB-1:0] low_bit(input logic [WB-1:0] m);
		logic [LSB-1:0] idx;
		idx = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = LSB'(i);
			end
		end
		return idx;
	endfunction

	// Clamp a zone bound to the bitmap size.
	function automatic logic [PW-1:0] clamp(input logic [bpra_pkg::CFG_W-1:0] v);
		return (32'(v) > PAGE_TOTAL) ? PW'(PAGE_TOTAL) : PW'(v);
	endfunction

	// Bitmap memory.
	bpra_bitmap_mem #(
		.DEPTH (NW),
		.AW    (WAW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Zone bounds selected by the incoming request.
	logic [PW-1:0] zs_in;
	logic [PW-1:0] ze_in;
	logic [PW-1:0] ze_in_m1;

	always_comb begin
		zs_in = '0;
		ze_in = '0;
		case (zone_select)
			bpra_pkg::ZSEL_DMA: begin
				zs_in = '0;
				ze_in = clamp(dma_end_q);
			end
			bpra_pkg::ZSEL_NORMAL: begin
				zs_in = clamp(dma_end_q);
				ze_in = clamp(normal_end_q);
			end
			bpra_pkg::ZSEL_UNMAPPED: begin
				zs_in = clamp(normal_end_q);
				ze_in = clamp(total_q);
			end
			default: begin
				zs_in = '0;
				ze_in = '0;
			end
		endcase
		ze_in_m1 = ze_in - PW'(1);
	end

	// Scan check: free pages of the word just read, clipped to the zone, and
	// the first run end found with the tail of the previous word.
	logic [LSB-1:0] zlo;
	logic [WB-1:0]  zmask;
	logic [WB-1:0]  chk_free;
	logic [WB-1:0]  ends;
	logic           hit;
	logic [LSB-1:0] hit_idx;
	logic [PW-1:0]  first_calc;

	always_comb begin
		zlo   = (chk_w_s1 == zs_q[PW-1:LSB]) ? zs_q[LSB-1:0] : '0;
		zmask = ('1 << zlo);
		if (chk_w_s1 == ze_q[PW-1:LSB]) begin
			zmask = zmask & ((WB'(1) << ze_q[LSB-1:0]) - WB'(1));
		end
		chk_free   = ~rd_data & zmask;
		ends       = run_ends({chk_free, prev_free_q}, cnt_q);
		hit        = |ends;
		hit_idx    = low_bit(ends);
		first_calc = {chk_w_s1, hit_idx} - PW'(cnt_q) + PW'(1);
	end

	// Run update: the run spans the start word and possibly the next one.
	logic [SW-LSB-1:0]  w0;
	logic [SW-LSB:0]    w1;
	logic               w0_ok;
	logic               w1_ok;
	logic [2*WB-1:0]    rmask;
	logic [WB-1:0]      m_lo;
	logic [WB-1:0]      m_hi;
	logic               hi_needed;

	always_comb begin
		w0        = run_start_q[SW-1:LSB];
		w1        = {1'b0, w0} + (SW - LSB + 1)'(1);
		w0_ok     = 32'(w0) < NW;
		w1_ok     = 32'(w1) < NW;
		rmask     = {{WB{1'b0}}, (WB'(1) << cnt_q) - WB'(1)} << run_start_q[LSB-1:0];
		m_lo      = rmask[WB-1:0] & lim_mask(32'(w0));
		m_hi      = rmask[2*WB-1:WB] & lim_mask(32'(w1));
		hi_needed = w1_ok && (|rmask[2*WB-1:WB]);
	end

	// Memory access control per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_SCAN: begin
				rd_en   = !iss_done_q;
				rd_addr = iss_w_q[WAW-1:0];
			end
			ST_RUN_RD: begin
				rd_en   = w0_ok;
				rd_addr = w0[WAW-1:0];
			end
			ST_RUN_LO: begin
				wr_en   = w0_ok;
				wr_addr = w0[WAW-1:0];
				wr_data = set_q ? (rd_data | m_lo) : (rd_data & ~m_lo);
				rd_en   = hi_needed;
				rd_addr = w1[WAW-1:0];
			end
			ST_RUN_HI: begin
				wr_en   = 1'b1;
				wr_addr = w1[WAW-1:0];
				wr_data = set_q ? (rd_data | m_hi) : (rd_data & ~m_hi);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_end_q    <= '0;
			normal_end_q <= '0;
			total_q      <= bpra_pkg::TOTAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpra_pkg::CFG_DMA_END:    dma_end_q    <= cfg_data;
				bpra_pkg::CFG_NORMAL_END: normal_end_q <= cfg_data;
				bpra_pkg::CFG_TOTAL:      total_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request sequencer with registered response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			run_start_q  <= '0;
			set_q        <= 1'b0;
			zs_q         <= '0;
			ze_q         <= '0;
			iss_w_q      <= '0;
			last_w_q     <= '0;
			iss_done_q   <= 1'b0;
			chk_v_s1     <= 1'b0;
			chk_w_s1     <= '0;
			prev_free_q  <= '0;
			res_status_q <= bpra_pkg::ST_OK;
			res_first_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= bpra_pkg::ST_OK;
			first_page_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q        <= page_count;
						res_first_q  <= '0;
						res_status_q <= bpra_pkg::ST_OK;
						if (mode != bpra_pkg::MODE_ALLOC && mode != bpra_pkg::MODE_FREE
								&& mode != bpra_pkg::MODE_MARK) begin
							res_status_q <= bpra_pkg::ST_BAD_ZONE;
							state_q      <= ST_RESP;
						end else if (page_count == '0 || 32'(page_count) > bpra_pkg::MAX_RUN) begin
							res_status_q <= bpra_pkg::ST_BAD_COUNT;
							state_q      <= ST_RESP;
						end else if (mode != bpra_pkg::MODE_ALLOC) begin
							run_start_q <= SW'(page_index);
							set_q       <= (mode == bpra_pkg::MODE_MARK);
							state_q     <= ST_RUN_RD;
						end else if (zone_select != bpra_pkg::ZSEL_DMA
								&& zone_select != bpra_pkg::ZSEL_NORMAL
								&& zone_select != bpra_pkg::ZSEL_UNMAPPED) begin
							res_status_q <= bpra_pkg::ST_BAD_ZONE;
							state_q      <= ST_RESP;
						end else if (ze_in <= zs_in) begin
							res_status_q <= bpra_pkg::ST_NO_RUN;
							state_q      <= ST_RESP;
						end else begin
							zs_q        <= zs_in;
							ze_q        <= ze_in;
							iss_w_q     <= zs_in[PW-1:LSB];
							last_w_q    <= ze_in_m1[PW-1:LSB];
							iss_done_q  <= 1'b0;
							chk_v_s1    <= 1'b0;
							prev_free_q <= '0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// Issue the next word read while checking the previous one.
					if (!iss_done_q) begin
						iss_w_q    <= iss_w_q + WCW'(1);
						iss_done_q <= (iss_w_q == last_w_q);
						chk_v_s1   <= 1'b1;
						chk_w_s1   <= iss_w_q;
					end else begin
						chk_v_s1 <= 1'b0;
					end
					if (chk_v_s1) begin
						if (hit) begin
							run_start_q <= SW'(first_calc);
							res_first_q <= bpra_pkg::INDEX_W'(first_calc);
							set_q       <= 1'b1;
							chk_v_s1    <= 1'b0;
							state_q     <= ST_RUN_RD;
						end else begin
							prev_free_q <= chk_free;
							if (chk_w_s1 == last_w_q) begin
								res_status_q <= bpra_pkg::ST_NO_RUN;
								state_q      <= ST_RESP;
							end
						end
					end
				end
				ST_RUN_RD: begin
					state_q <= ST_RUN_LO;
				end
				ST_RUN_LO: begin
					state_q <= hi_needed ? ST_RUN_HI : ST_RESP;
				end
				ST_RUN_HI: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						first_page_q <= res_first_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign first_page = first_page_q;

	// The bitmap is never written while a zone scan is in progress.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("bitmap written during zone scan");

	// A new response is only presented from the response state.
	a_resp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("response raised outside response state");

	// A run found by the scan lies wholly inside the zone.
	a_run_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN_RD && $past(state_q) == ST_SCAN)
		|-> (32'(run_start_q) >= 32'(zs_q)
			&& 32'(run_start_q) + 32'(cnt_q) <= 32'(ze_q)))
		else $error("allocated run outside selected zone");

endmodule

// ----- rtl/bpra_bitmap_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word memory
// Simple dual-port synchronous memory holding the page bitmap, one write and
// one read per cycle, registered read data. A per-word valid bit cleared by
// reset makes every unwritten word read as all pages free.
// ----------------------------------------------------------------------------
module bpra_bitmap_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [bpra_pkg::WORD_BITS-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bpra_pkg::WORD_BITS-1:0] wr_data
);

	logic [bpra_pkg::WORD_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]               vld_q;
	logic [bpra_pkg::WORD_BITS-1:0] rd_word_s1;
	logic                           rd_vld_s1;

	// Storage array: write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[rd_addr];
		end
	end

	// Word valid bits, cleared at reset so the bitmap starts all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// A word never written reads as zero.
	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page run allocator testbench
// Drives allocate, free and mark-used requests into the allocator and keeps
// its own copy of the used-page bitmap and zone bounds to predict every
// response. A short directed sequence covers the boundaries and error codes,
// then random requests run over a series of zone settings with varied
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;

	// Field types of the request, response and configuration port.
	typedef logic [bpra_pkg::MODE_W-1:0]    mode_bits_t;
	typedef logic [bpra_pkg::ZONE_W-1:0]    zone_bits_t;
	typedef logic [bpra_pkg::COUNT_W-1:0]   count_bits_t;
	typedef logic [bpra_pkg::INDEX_W-1:0]   index_bits_t;
	typedef logic [bpra_pkg::STAT_W-1:0]    stat_bits_t;
	typedef logic [bpra_pkg::CFG_W-1:0]     cfg_bits_t;
	typedef logic [bpra_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	localparam int PAGE_TOTAL  = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEGMENTS    = 9;
	localparam int SEGMENT_LEN = 205;
	localparam int SETTLE      = 16;

	localparam count_bits_t RUN_MAX   = count_bits_t'(bpra_pkg::MAX_RUN);
	localparam index_bits_t LAST_PAGE = index_bits_t'(PAGE_TOTAL - 1);

	// Codes that the package leaves unnamed.
	localparam mode_bits_t MODE_RESERVED = 2'd3;
	localparam zone_bits_t ZONE_INVALID  = 2'd3;

	// Zone settings per random segment; a negative entry means a random one.
	int seg_dma    [SEGMENTS] = '{1024, 0, 4096, 64, 8191, 3000, -1, 100, -1};
	int seg_normal [SEGMENTS] = '{2048, 0, 4096, 128, 8191, 1000, -1, 4000, -1};
	int seg_total  [SEGMENTS] = '{4096, 4096, 4096, 192, 8191, 2000, -1, 0, -1};

	// ------------------------------------------------------------------
	// Shadow of the allocator: bitmap, zone bounds and awaited responses.
	// ------------------------------------------------------------------
	class page_map_scoreboard;
		typedef struct packed {
			stat_bits_t  code;
			index_bits_t page;
		} response_t;

		typedef struct {
			int start_page;
			int length;
		} page_run_t;

		bit                used_page [PAGE_TOTAL];
		cfg_bits_t         zone_bound [3];
		response_t         awaited [$];
		page_run_t         live_runs [$];
		int                errors;

		function new();
			foreach (used_page[i])
				used_page[i] = 1'b0;
			zone_bound[bpra_pkg::CFG_DMA_END]    = '0;
			zone_bound[bpra_pkg::CFG_NORMAL_END] = '0;
			zone_bound[bpra_pkg::CFG_TOTAL]      = bpra_pkg::TOTAL_RESET;
			errors = 0;
		endfunction

		function void write_register(cfg_idx_t idx, cfg_bits_t value);
			zone_bound[idx] = value;
		endfunction

		function int clamp_bound(cfg_bits_t value);
			return (int'(value) > PAGE_TOTAL) ? PAGE_TOTAL : int'(value);
		endfunction

		// Pages at or beyond the end of the bitmap are left alone.
		function void write_run(int start_page, int length, bit value);
			int p;
			for (p = start_page; p < start_page + length; p++)
				if (p < PAGE_TOTAL)
					used_page[p] = value;
		endfunction

		// Works out the response to an accepted request and applies its effect.
		function void note_request(mode_bits_t req_mode, zone_bits_t req_zone,
				count_bits_t req_count, index_bits_t req_index);
			response_t want;
			page_run_t run_rec;
			int zs, ze, p, run;
			bit found;
			want.code = bpra_pkg::ST_OK;
			want.page = '0;
			found = 1'b0;
			run = 0;
			if (req_mode == MODE_RESERVED) begin
				want.code = bpra_pkg::ST_BAD_ZONE;
			end else if (req_count == '0 || int'(req_count) > bpra_pkg::MAX_RUN) begin
				want.code = bpra_pkg::ST_BAD_COUNT;
			end else if (req_mode == bpra_pkg::MODE_FREE) begin
				write_run(int'(req_index), int'(req_count), 1'b0);
			end else if (req_mode == bpra_pkg::MODE_MARK) begin
				write_run(int'(req_index), int'(req_count), 1'b1);
			end else if (req_zone == ZONE_INVALID) begin
				want.code = bpra_pkg::ST_BAD_ZONE;
			end else begin
				case (req_zone)
					bpra_pkg::ZSEL_DMA: begin
						zs = 0;
						ze = clamp_bound(zone_bound[bpra_pkg::CFG_DMA_END]);
					end
					bpra_pkg::ZSEL_NORMAL: begin
						zs = clamp_bound(zone_bound[bpra_pkg::CFG_DMA_END]);
						ze = clamp_bound(zone_bound[bpra_pkg::CFG_NORMAL_END]);
					end
					default: begin
						zs = clamp_bound(zone_bound[bpra_pkg::CFG_NORMAL_END]);
						ze = clamp_bound(zone_bound[bpra_pkg::CFG_TOTAL]);
					end
				endcase
				// First fit: the lowest run of free pages inside the zone.
				for (p = zs; p < ze && !found; p++) begin
					if (used_page[p]) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(req_count)) begin
							want.page = index_bits_t'(p + 1 - int'(req_count));
							found = 1'b1;
						end
					end
				end
				if (found) begin
					write_run(int'(want.page), int'(req_count), 1'b1);
					run_rec.start_page = int'(want.page);
					run_rec.length = int'(req_count);
					live_runs.push_back(run_rec);
				end else begin
					want.code = bpra_pkg::ST_NO_RUN;
					want.page = '0;
				end
			end
			awaited.push_back(want);
		endfunction

		// Compares an accepted response with the oldest awaited one.
		function void check_response(stat_bits_t code, index_bits_t page);
			response_t want;
			if (awaited.size() == 0) begin
				$display("%0t: response status %0d first_page %0d with none awaited",
					$time, code, page);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (want.code !== code) begin
				$display("%0t: status expected %0d, actual %0d", $time, want.code, code);
				errors++;
			end
			if (want.page !== page) begin
				$display("%0t: first_page expected %0d, actual %0d", $time, want.page, page);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Signals and the block under test.
	// ------------------------------------------------------------------
	logic         clk;
	logic         arst_n      = 1'b0;
	logic         cfg_we      = 1'b0;
	cfg_idx_t     cfg_index   = bpra_pkg::CFG_DMA_END;
	cfg_bits_t    cfg_data    = '0;
	logic         in_valid    = 1'b0;
	logic         in_stall;
	mode_bits_t   mode        = bpra_pkg::MODE_ALLOC;
	zone_bits_t   zone_select = bpra_pkg::ZSEL_DMA;
	count_bits_t  page_count  = '0;
	index_bits_t  page_index  = '0;
	logic         out_valid;
	logic         out_stall   = 1'b0;
	stat_bits_t   status;
	index_bits_t  first_page;

	page_map_scoreboard board;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	bitmap_page_run_allocator_unit #(
		.PAGE_TOTAL(PAGE_TOTAL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.zone_select(zone_select),
		.page_count(page_count),
		.page_index(page_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.first_page(first_page)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Random back-pressure on the response channel.
	always @(posedge clk) begin
		out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// Responses are checked before requests are noted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_response(status, first_page);
			if (in_valid && !in_stall)
				board.note_request(mode, zone_select, page_count, page_index);
		end
	end

	// ------------------------------------------------------------------
	// Drive tasks.
	// ------------------------------------------------------------------

	// Presents one request, with random gaps first, and waits for acceptance.
	task automatic send_request(mode_bits_t m, zone_bits_t z, count_bits_t n, index_bits_t p);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		zone_select <= z;
		page_count  <= n;
		page_index  <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Lowers valid and waits for every awaited response to arrive.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all three zone bounds on consecutive cycles.
	task automatic set_zones(int dma_end, int normal_end, int total);
		cfg_bits_t value [3];
		int i;
		value[bpra_pkg::CFG_DMA_END]    = cfg_bits_t'(dma_end);
		value[bpra_pkg::CFG_NORMAL_END] = cfg_bits_t'(normal_end);
		value[bpra_pkg::CFG_TOTAL]      = cfg_bits_t'(total);
		for (i = 0; i < 3; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= value[i];
			board.write_register(cfg_idx_t'(i), value[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed allocate and free traffic, with marks and bad requests.
	task automatic send_random_request();
		int pick, slot;
		mode_bits_t  m;
		zone_bits_t  z;
		count_bits_t n;
		index_bits_t p;
		pick = int'($urandom_range(99));
		m = bpra_pkg::MODE_ALLOC;
		z = zone_bits_t'($urandom_range(2));
		n = ($urandom_range(99) < 80) ? count_bits_t'($urandom_range(8, 1))
			: count_bits_t'($urandom_range(bpra_pkg::MAX_RUN, 1));
		p = index_bits_t'($urandom_range(PAGE_TOTAL - 1));
		if (pick < 45) begin
			m = bpra_pkg::MODE_ALLOC;
		end else if (pick < 75) begin
			m = bpra_pkg::MODE_FREE;
			// Usually return a run that was handed out earlier.
			if (board.live_runs.size() != 0 && $urandom_range(9) != 0) begin
				slot = int'($urandom_range(board.live_runs.size() - 1));
				p = index_bits_t'(board.live_runs[slot].start_page);
				n = count_bits_t'(board.live_runs[slot].length);
				board.live_runs.delete(slot);
			end
		end else if (pick < 87) begin
			m = bpra_pkg::MODE_MARK;
		end else begin
			case ($urandom_range(3))
				0: begin
					m = mode_bits_t'($urandom_range(2));
					n = '0;
				end
				1: z = ZONE_INVALID;
				2: m = MODE_RESERVED;
				default: begin
					m = mode_bits_t'($urandom);
					z = zone_bits_t'($urandom);
					n = count_bits_t'($urandom);
					p = index_bits_t'($urandom);
				end
			endcase
		end
		send_request(m, z, n, p);
	endtask

	// Selects how both channels idle for a phase.
	task automatic set_idling(int phase);
		case (phase % 3)
			0: begin
				send_idle_pct  = 10;
				recv_stall_pct = 65;
			end
			1: begin
				send_idle_pct  = 65;
				recv_stall_pct = 10;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int seg, k, dma_end, normal_end, total;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		// Ordinary zones: first fit at each zone start, error codes, edge runs.
		set_zones(1024, 2048, 4096);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, 1, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, RUN_MAX, LAST_PAGE);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_NORMAL, RUN_MAX, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_UNMAPPED, RUN_MAX, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_UNMAPPED, 1, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, 0, 0);
		send_request(bpra_pkg::MODE_FREE, bpra_pkg::ZSEL_DMA, 0, 5);
		send_request(bpra_pkg::MODE_MARK, bpra_pkg::ZSEL_DMA, 0, 5);
		send_request(bpra_pkg::MODE_ALLOC, ZONE_INVALID, 5, 0);
		send_request(MODE_RESERVED, bpra_pkg::ZSEL_DMA, 5, 0);
		send_request(MODE_RESERVED, ZONE_INVALID, 0, LAST_PAGE);
		// A run reaching past the end of the bitmap, and a free with an invalid zone code.
		send_request(bpra_pkg::MODE_MARK, bpra_pkg::ZSEL_DMA, RUN_MAX, LAST_PAGE);
		send_request(bpra_pkg::MODE_FREE, ZONE_INVALID, RUN_MAX, 4000);
		// Freeing and marking pages already in that state.
		send_request(bpra_pkg::MODE_FREE, bpra_pkg::ZSEL_UNMAPPED, RUN_MAX, 1);
		send_request(bpra_pkg::MODE_FREE, bpra_pkg::ZSEL_NORMAL, RUN_MAX, 1);
		send_request(bpra_pkg::MODE_MARK, bpra_pkg::ZSEL_DMA, 20, 100);
		send_request(bpra_pkg::MODE_MARK, bpra_pkg::ZSEL_DMA, 20, 90);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, RUN_MAX, 0);
		send_request(bpra_pkg::MODE_MARK, bpra_pkg::ZSEL_NORMAL, 4, 3000);
		drain();

		// Tiny DMA zone, bounds out of order and clamped total.
		set_zones(5, 2, 8191);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, 6, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, 4, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_NORMAL, 1, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_UNMAPPED, RUN_MAX, 0);
		drain();

		// Every zone empty.
		set_zones(0, 0, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_DMA, 1, 0);
		send_request(bpra_pkg::MODE_ALLOC, bpra_pkg::ZSEL_UNMAPPED, 1, 0);
		drain();

		// Random phases over a range of zone settings; the idling pattern
		// changes every third segment and ends with neither side idling.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg_dma[seg] < 0) begin
				dma_end    = int'($urandom_range(2048));
				normal_end = dma_end + int'($urandom_range(2048));
				total      = int'($urandom_range(8191, normal_end));
			end else begin
				dma_end    = seg_dma[seg];
				normal_end = seg_normal[seg];
				total      = seg_total[seg];
			end
			set_zones(dma_end, normal_end, total);
			set_idling(seg / 3);
			for (k = 0; k < SEGMENT_LEN; k++)
				send_random_request();
			drain();
		end

		if (board.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
